// File: hdl/memory_region_map_carver_macros.svh
// Assertion macros shared by the memory region map carver.
// Both expect signals named clk and arst_n in the module that uses them.
`ifndef MEMORY_REGION_MAP_CARVER_MACROS_SVH
`define MEMORY_REGION_MAP_CARVER_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MRMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("memory region map carver: same-cycle check failed");

// The consequence must hold in the cycle after the antecedent.
`define MRMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("memory region map carver: next-cycle check failed");

`endif

// File: hdl/mrmc_pkg.sv
package mrmc_pkg;

	// Default table depth.
	localparam int DEF_MAX_ENTRIES = 128;

	// Type codes with a fixed meaning.
	localparam logic [31:0] KIND_AVAILABLE = 32'd1;
	localparam logic [31:0] KIND_ALL_ONES  = 32'hFFFF_FFFF;

	// End limit after reset: 4 GiB.
	localparam logic [63:0] RESET_LIMIT = 64'h0000_0001_0000_0000;

	typedef enum logic [1:0] {
		ACT_LOAD,
		ACT_RESERVE,
		ACT_FIND,
		ACT_EXPORT
	} action_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_FULL,
		ST_NOFIT,
		ST_AVAIL,
		ST_ALLONES,
		ST_EMPTY
	} status_t;

	// How a reserve carves the region it hits.
	typedef enum logic [1:0] {
		RC_RETYPE,
		RC_HEAD,
		RC_TAIL,
		RC_MID
	} carve_t;

	// Per-entry decisions from the shared compare unit.
	typedef struct packed {
		logic is_last;
		logic res_hit;
		logic at_start;
		logic at_end;
		logic same_len;
		logic fl_take;
		logic ex_join;
	} alu_flags_t;

endpackage

// File: hdl/mrmc_table.sv
module mrmc_table #(
	parameter int MAX_ENTRIES = mrmc_pkg::DEF_MAX_ENTRIES,
	parameter int IW = $clog2(MAX_ENTRIES)
) (
	input  logic          clk,
	input  logic [IW-1:0] raddr,
	input  logic          we_main,
	input  logic          we_link,
	input  logic [IW-1:0] waddr,
	input  logic [63:0]   wbase,
	input  logic [63:0]   wlen,
	input  logic [31:0]   wkind,
	input  logic [IW-1:0] wlink,
	output logic [63:0]   rbase,
	output logic [63:0]   rlen,
	output logic [31:0]   rkind,
	output logic [IW-1:0] rlink
);

	logic [63:0]   base_mem [MAX_ENTRIES];
	logic [63:0]   len_mem  [MAX_ENTRIES];
	logic [31:0]   kind_mem [MAX_ENTRIES];
	logic [IW-1:0] link_mem [MAX_ENTRIES];

	// One shared write address; the link field has its own enable.
	always_ff @(posedge clk) begin
		if (we_main) begin
			base_mem[waddr] <= wbase;
			len_mem[waddr]  <= wlen;
			kind_mem[waddr] <= wkind;
		end
		if (we_link) begin
			link_mem[waddr] <= wlink;
		end
	end

	// Registered read of one entry.
	always_ff @(posedge clk) begin
		rbase <= base_mem[raddr];
		rlen  <= len_mem[raddr];
		rkind <= kind_mem[raddr];
		rlink <= link_mem[raddr];
	end

endmodule

// File: hdl/mrmc_alu.sv
module mrmc_alu #(
	parameter int IW = 7,
	parameter int CW = 8
) (
	input  logic [63:0]          ent_base,
	input  logic [63:0]          ent_len,
	input  logic [31:0]          ent_kind,
	input  logic [IW-1:0]        ent_link,
	input  logic [CW-1:0]        used,
	input  logic [63:0]          req_base,
	input  logic [63:0]          req_len,
	input  logic [64:0]          req_end,
	input  logic [63:0]          end_limit,
	input  logic [63:0]          best,
	input  logic [64:0]          acc_end,
	input  logic [63:0]          acc_len,
	input  logic [31:0]          temp,
	output logic [64:0]          ent_end,
	output logic [IW-1:0]        nxt,
	output logic [63:0]          acc_sum,
	output mrmc_pkg::alu_flags_t flags
);

	logic        avail;
	logic [64:0] len_sum;

	// Exact end of the entry and the accumulated merge length.
	assign ent_end = {1'b0, ent_base} + {1'b0, ent_len};
	assign len_sum = {1'b0, acc_len} + {1'b0, ent_len};
	assign acc_sum = len_sum[63:0];

	// A link past the used part of the table ends the list.
	assign nxt   = (CW'(ent_link) < used) ? ent_link : '0;
	assign avail = (ent_kind == mrmc_pkg::KIND_AVAILABLE);

	// Decisions for each action against the entry just read.
	always_comb begin
		flags.is_last  = (nxt == '0);
		flags.res_hit  = avail && (req_base >= ent_base) && (req_end <= ent_end);
		flags.at_start = (req_base == ent_base);
		flags.at_end   = (req_end == ent_end);
		flags.same_len = (req_len == ent_len);
		flags.fl_take  = avail && (ent_len > best) && (ent_end <= {1'b0, end_limit});
		flags.ex_join  = (ent_kind == temp) && (acc_end == {1'b0, ent_base}) && !len_sum[64];
	end

endmodule

// File: hdl/memory_region_map_carver.sv
// Memory region map carver: a linked table of memory regions.
// Input items arrive on s_tvalid/s_tready with s_tuser = {start_req, action}
// and s_tdata = {region_type, region_length, region_base}. Every item gives
// one result on m_tvalid/m_tready with m_tuser = status, m_tlast = last and
// m_tdata = {temp_type, out_type, out_length, out_base}.
// The block takes one item at a time and is ready again in the cycle after
// the result is loaded. A load passes through dispatch, one or two table
// writes and the result state; a refused load goes from dispatch straight
// to the result state. Reserve, find-largest and export walk the list one
// entry per cycle, since the table has a single read port; a reserve that
// hits then writes the table once, twice or three times (a split in three).
// The result register is separate, so the next item is taken while a result
// waits; a finished item that meets a stalled receiver holds until the
// result register is free.
// The user writes end_limit through cfg_wen/cfg_wdata while the block is idle;
// the block itself does not enforce this. Reset clears the table count, the
// largest type, the export cursor and the limit (back to 4 GiB); table memory
// is not cleared, and entries past the fill count are never read.
`include "memory_region_map_carver_macros.svh"

module memory_region_map_carver #(
	parameter int MAX_ENTRIES = mrmc_pkg::DEF_MAX_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [63:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] action, [2] start_req
	input  logic [2:0]   s_tuser,
	// [63:0] region_base, [127:64] region_length, [159:128] region_type
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [2:0] status
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	// [63:0] out_base, [127:64] out_length, [159:128] out_type,
	// [191:160] temp_type
	output logic [191:0] m_tdata
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DSP,
		S_WALK,
		S_WR,
		S_FIN
	} state_t;

	state_t                state_q;
	mrmc_pkg::action_t     act_q;
	mrmc_pkg::status_t     st_q;
	mrmc_pkg::carve_t      carve_q;
	logic [63:0]           base_q, len_q, limit_q, best_q, ob_q, ol_q, a_q, l_q;
	logic [31:0]           kind_q, largest_q, ot_q, ek_q;
	logic [64:0]           rend_q, end_q;
	logic [CW-1:0]         used_q;
	logic [IW-1:0]         tail_q, cursor_q, idx_q, hit_q, lk_q;
	logic                  first_q, last_q, was_tail_q;
	logic [1:0]            wstep_q, wlast_q;

	logic [IW-1:0]         raddr, waddr, wlink, rlink, nxt, cur_start, used_ix, used_ix1;
	logic                  we_main, we_link;
	logic [63:0]           wbase, wlen, rbase, rlen, acc_sum;
	logic [31:0]           wkind, rkind, temp;
	logic [64:0]           ent_end;
	logic [1:0]            need;
	logic                  ot_avail;
	mrmc_pkg::alu_flags_t  flags;

	assign s_tready  = (state_q == S_IDLE);
	assign temp      = largest_q + 32'd1;
	assign used_ix   = IW'(used_q);
	assign used_ix1  = IW'(used_q + CW'(1));
	assign cur_start = (CW'(cursor_q) >= used_q) ? '0 : cursor_q;
	assign ot_avail  = (rkind == temp) || (rkind == mrmc_pkg::KIND_AVAILABLE);
	assign need      = flags.same_len ? 2'd0 : ((flags.at_start || flags.at_end) ? 2'd1 : 2'd2);

	mrmc_table #(.MAX_ENTRIES(MAX_ENTRIES), .IW(IW)) u_table (
		.clk(clk), .raddr(raddr), .we_main(we_main), .we_link(we_link), .waddr(waddr),
		.wbase(wbase), .wlen(wlen), .wkind(wkind), .wlink(wlink),
		.rbase(rbase), .rlen(rlen), .rkind(rkind), .rlink(rlink)
	);

	mrmc_alu #(.IW(IW), .CW(CW)) u_alu (
		.ent_base(rbase), .ent_len(rlen), .ent_kind(rkind), .ent_link(rlink),
		.used(used_q), .req_base(base_q), .req_len(len_q), .req_end(rend_q),
		.end_limit(limit_q), .best(best_q), .acc_end(end_q), .acc_len(ol_q),
		.temp(temp), .ent_end(ent_end), .nxt(nxt), .acc_sum(acc_sum), .flags(flags)
	);

	// Read address: list head or cursor at dispatch, next link while walking.
	always_comb begin
		raddr = idx_q;
		if (state_q == S_DSP) begin
			raddr = (act_q == mrmc_pkg::ACT_EXPORT) ? cur_start : '0;
		end else if (state_q == S_WALK) begin
			raddr = nxt;
		end
	end

	// Table writes for load and for the carving steps of reserve.
	always_comb begin
		we_main = 1'b0;
		we_link = 1'b0;
		waddr   = used_ix;
		wbase   = base_q;
		wlen    = len_q;
		wkind   = kind_q;
		wlink   = lk_q;
		if (state_q == S_WR) begin
			if (act_q == mrmc_pkg::ACT_LOAD) begin
				if (wstep_q == 2'd0) begin
					we_main = 1'b1;
					we_link = 1'b1;
					wlink   = '0;
				end else begin
					we_link = 1'b1;
					waddr   = tail_q;
					wlink   = used_ix;
				end
			end else begin
				we_main = 1'b1;
				we_link = 1'b1;
				case (carve_q)
					mrmc_pkg::RC_RETYPE: begin
						waddr = hit_q;
						wbase = a_q;
						wlen  = l_q;
					end
					mrmc_pkg::RC_HEAD: begin
						if (wstep_q == 2'd0) begin
							wbase = rend_q[63:0];
							wlen  = l_q - len_q;
							wkind = mrmc_pkg::KIND_AVAILABLE;
						end else begin
							waddr = hit_q;
							wbase = a_q;
							wlink = used_ix;
						end
					end
					mrmc_pkg::RC_TAIL: begin
						if (wstep_q != 2'd0) begin
							waddr = hit_q;
							wbase = a_q;
							wlen  = l_q - len_q;
							wkind = ek_q;
							wlink = used_ix;
						end
					end
					default: begin
						if (wstep_q == 2'd0) begin
							wbase = rend_q[63:0];
							wlen  = a_q + l_q - rend_q[63:0];
							wkind = mrmc_pkg::KIND_AVAILABLE;
						end else if (wstep_q == 2'd1) begin
							waddr = used_ix1;
							wlink = used_ix;
						end else begin
							waddr = hit_q;
							wbase = a_q;
							wlen  = base_q - a_q;
							wkind = ek_q;
							wlink = used_ix1;
						end
					end
				endcase
			end
		end
	end

	// Sequencer, table state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			tail_q     <= '0;
			cursor_q   <= '0;
			largest_q  <= '0;
			limit_q    <= mrmc_pkg::RESET_LIMIT;
			m_tvalid   <= 1'b0;
			act_q      <= mrmc_pkg::ACT_LOAD;
			st_q       <= mrmc_pkg::ST_OK;
			carve_q    <= mrmc_pkg::RC_RETYPE;
			first_q    <= 1'b0;
			last_q     <= 1'b0;
			was_tail_q <= 1'b0;
			wstep_q    <= '0;
			wlast_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (cfg_wen) begin
				limit_q <= cfg_wdata;
			end
			// A result taken while the next one is loaded keeps the valid high.
			if (m_tvalid && m_tready && state_q != S_FIN) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						act_q  <= mrmc_pkg::action_t'(s_tuser[1:0]);
						base_q <= s_tdata[63:0];
						len_q  <= s_tdata[127:64];
						kind_q <= s_tdata[159:128];
						rend_q <= {1'b0, s_tdata[63:0]} + {1'b0, s_tdata[127:64]};
						st_q   <= mrmc_pkg::ST_OK;
						ob_q   <= '0;
						ol_q   <= '0;
						ot_q   <= '0;
						last_q <= 1'b0;
						best_q <= '0;
						if (s_tuser[2]) begin
							if (mrmc_pkg::action_t'(s_tuser[1:0]) == mrmc_pkg::ACT_LOAD) begin
								cursor_q  <= '0;
								used_q    <= '0;
								tail_q    <= '0;
								largest_q <= '0;
							end else if (mrmc_pkg::action_t'(s_tuser[1:0]) ==
									mrmc_pkg::ACT_EXPORT) begin
								cursor_q <= '0;
							end
						end
						state_q <= S_DSP;
					end
				end
				S_DSP: begin
					wstep_q <= '0;
					idx_q   <= (act_q == mrmc_pkg::ACT_EXPORT) ? cur_start : '0;
					case (act_q)
						mrmc_pkg::ACT_LOAD: begin
							if (kind_q == mrmc_pkg::KIND_ALL_ONES) begin
								st_q    <= mrmc_pkg::ST_ALLONES;
								state_q <= S_FIN;
							end else if (used_q >= CW'(MAX_ENTRIES)) begin
								st_q    <= mrmc_pkg::ST_FULL;
								state_q <= S_FIN;
							end else begin
								wlast_q <= (used_q == '0) ? 2'd0 : 2'd1;
								state_q <= S_WR;
							end
						end
						mrmc_pkg::ACT_RESERVE: begin
							if (len_q == '0) begin
								st_q    <= mrmc_pkg::ST_OK;
								state_q <= S_FIN;
							end else if (kind_q == mrmc_pkg::KIND_AVAILABLE) begin
								st_q    <= mrmc_pkg::ST_AVAIL;
								state_q <= S_FIN;
							end else if (used_q == '0) begin
								st_q    <= mrmc_pkg::ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								state_q <= S_WALK;
							end
						end
						mrmc_pkg::ACT_FIND: begin
							if (used_q == '0) begin
								st_q    <= mrmc_pkg::ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								st_q    <= mrmc_pkg::ST_NOFIT;
								state_q <= S_WALK;
							end
						end
						default: begin
							if (used_q == '0) begin
								st_q    <= mrmc_pkg::ST_EMPTY;
								last_q  <= 1'b1;
								state_q <= S_FIN;
							end else begin
								first_q <= 1'b1;
								state_q <= S_WALK;
							end
						end
					endcase
				end
				S_WALK: begin
					idx_q <= nxt;
					case (act_q)
						mrmc_pkg::ACT_RESERVE: begin
							if (flags.res_hit) begin
								a_q        <= rbase;
								l_q        <= rlen;
								ek_q       <= rkind;
								lk_q       <= rlink;
								hit_q      <= idx_q;
								was_tail_q <= flags.is_last;
								wlast_q    <= (need == 2'd0) ? 2'd0 :
									((flags.at_start || flags.at_end) ? 2'd1 : 2'd2);
								if (flags.same_len) begin
									carve_q <= mrmc_pkg::RC_RETYPE;
								end else if (flags.at_start) begin
									carve_q <= mrmc_pkg::RC_HEAD;
								end else if (flags.at_end) begin
									carve_q <= mrmc_pkg::RC_TAIL;
								end else begin
									carve_q <= mrmc_pkg::RC_MID;
								end
								if (({1'b0, used_q} + (CW+1)'(need)) > (CW+1)'(MAX_ENTRIES)) begin
									st_q    <= mrmc_pkg::ST_FULL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_WR;
								end
							end else if (flags.is_last) begin
								st_q    <= mrmc_pkg::ST_NOFIT;
								state_q <= S_FIN;
							end
						end
						mrmc_pkg::ACT_FIND: begin
							if (flags.fl_take) begin
								best_q <= rlen;
								ob_q   <= rbase;
								ol_q   <= rlen;
								st_q   <= mrmc_pkg::ST_OK;
							end
							if (flags.is_last) begin
								state_q <= S_FIN;
							end
						end
						default: begin
							if (first_q) begin
								first_q <= 1'b0;
								ob_q    <= rbase;
								ol_q    <= rlen;
								end_q   <= ent_end;
								ot_q    <= ot_avail ? mrmc_pkg::KIND_AVAILABLE : rkind;
								if (!ot_avail || flags.is_last) begin
									cursor_q <= nxt;
									last_q   <= flags.is_last;
									state_q  <= S_FIN;
								end
							end else if (flags.ex_join) begin
								ol_q  <= acc_sum;
								end_q <= ent_end;
								if (flags.is_last) begin
									cursor_q <= '0;
									last_q   <= 1'b1;
									state_q  <= S_FIN;
								end
							end else begin
								cursor_q <= idx_q;
								last_q   <= 1'b0;
								state_q  <= S_FIN;
							end
						end
					endcase
				end
				S_WR: begin
					wstep_q <= wstep_q + 2'd1;
					if (wstep_q == wlast_q) begin
						state_q <= S_FIN;
						st_q    <= mrmc_pkg::ST_OK;
						if (act_q == mrmc_pkg::ACT_LOAD) begin
							used_q <= used_q + CW'(1);
							tail_q <= used_ix;
							if (kind_q > largest_q) begin
								largest_q <= kind_q;
							end
						end else begin
							used_q <= used_q + CW'(wlast_q);
							if (was_tail_q) begin
								if (carve_q == mrmc_pkg::RC_HEAD || carve_q == mrmc_pkg::RC_TAIL) begin
									tail_q <= used_ix;
								end else if (carve_q == mrmc_pkg::RC_MID) begin
									tail_q <= used_ix;
								end
							end
						end
					end
				end
				S_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tuser  <= st_q;
						m_tlast  <= last_q;
						m_tdata  <= {temp, ot_q, ol_q, ob_q};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and the table bookkeeping.
	`MRMC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`MRMC_ASSERT_NOW(a_used_bound, 1'b1, used_q <= CW'(MAX_ENTRIES))
	`MRMC_ASSERT_NOW(a_tail_in_table, used_q != '0, CW'(tail_q) < used_q)
	`MRMC_ASSERT_NEXT(a_result_loaded, state_q == S_FIN && (!m_tvalid || m_tready),
		m_tvalid && state_q == S_IDLE)

endmodule
